FILE: hw/rtl/tlso_pkg.sv
// Package with the shared types and codes of the traffic light sensor override unit.
`timescale 1ns / 1ps

package tlso_pkg;

  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] phase_t;
  typedef logic [1:0] owner_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DUR_W-1:0] dur_t;

  localparam phase_t PH_A_GREEN  = 2'd0;
  localparam phase_t PH_A_YELLOW = 2'd1;
  localparam phase_t PH_B_GREEN  = 2'd2;
  localparam phase_t PH_B_YELLOW = 2'd3;

  localparam owner_t OWN_NONE = 2'd0;
  localparam owner_t OWN_A    = 2'd1;
  localparam owner_t OWN_B    = 2'd2;

  localparam cfg_idx_t CFG_GREEN_TIME    = 3'd0;
  localparam cfg_idx_t CFG_YELLOW_TIME   = 3'd1;
  localparam cfg_idx_t CFG_DEBOUNCE_TIME = 3'd2;
  localparam cfg_idx_t CFG_HOLD_TIME     = 3'd3;
  localparam cfg_idx_t CFG_A_ACTIVE      = 3'd4;
  localparam cfg_idx_t CFG_B_ACTIVE      = 3'd5;

  localparam dur_t GREEN_TIME_RST    = 16'd3000;
  localparam dur_t YELLOW_TIME_RST   = 16'd1000;
  localparam dur_t DEBOUNCE_TIME_RST = 16'd75;
  localparam dur_t HOLD_TIME_RST     = 16'd800;

  typedef struct packed {
    dur_t green_time;
    dur_t yellow_time;
    dur_t hold_time;
  } phase_cfg_t;

  typedef struct packed {
    logic   a_red;
    logic   a_amber;
    logic   a_green;
    logic   b_red;
    logic   b_amber;
    logic   b_green;
    phase_t phase;
    owner_t override_side;
    logic   a_detected;
    logic   b_detected;
  } result_t;

endpackage

FILE: hw/rtl/tlso_if.sv
// Handshake interfaces for the sensor item channel and the lamp result channel.
`timescale 1ns / 1ps

interface tlso_in_if;
  logic valid;
  logic ready;
  logic a_sensor_raw;
  logic b_sensor_raw;

  modport source (output valid, output a_sensor_raw, output b_sensor_raw, input ready);
  modport sink (input valid, input a_sensor_raw, input b_sensor_raw, output ready);
endinterface

interface tlso_out_if;
  import tlso_pkg::*;
  logic   valid;
  logic   ready;
  logic   a_red;
  logic   a_amber;
  logic   a_green;
  logic   b_red;
  logic   b_amber;
  logic   b_green;
  phase_t phase;
  owner_t override_side;
  logic   a_detected;
  logic   b_detected;

  modport source (
    output valid, output a_red, output a_amber, output a_green, output b_red,
    output b_amber, output b_green, output phase, output override_side,
    output a_detected, output b_detected, input ready
  );
  modport sink (
    input valid, input a_red, input a_amber, input a_green, input b_red,
    input b_amber, input b_green, input phase, input override_side,
    input a_detected, input b_detected, output ready
  );
endinterface

FILE: hw/rtl/tlso_debounce.sv
// Debouncer for one vehicle sensor, updated once per accepted item.
`timescale 1ns / 1ps

module tlso_debounce
  import tlso_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  raw,
  input  logic                  active_level,
  input  logic [TIME_WIDTH-1:0] now,
  input  dur_t                  debounce_time,
  output logic                  stable_nxt
);

  logic                  last_r, last_nxt;
  logic [TIME_WIDTH-1:0] chg_r, chg_nxt;
  logic                  stable_r;
  logic [TIME_WIDTH-1:0] held;

  assign held = now - chg_r;

  always_comb begin
    last_nxt   = last_r;
    chg_nxt    = chg_r;
    stable_nxt = stable_r;
    if (raw != last_r) begin
      last_nxt = raw;
      chg_nxt  = now;
    end else if (held >= TIME_WIDTH'(debounce_time)) begin
      stable_nxt = (raw == active_level);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b1;
      chg_r    <= '0;
      stable_r <= 1'b0;
    end else if (step) begin
      last_r   <= last_nxt;
      chg_r    <= chg_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

FILE: hw/rtl/tlso_phase_ctrl.sv
// Phase sequencer with timed phases and sensor-driven green override.
`timescale 1ns / 1ps

module tlso_phase_ctrl
  import tlso_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [TIME_WIDTH-1:0] now,
  input  phase_cfg_t            cfg,
  input  logic                  a_steady,
  input  logic                  b_steady,
  output phase_t                phase_nxt,
  output owner_t                owner_nxt
);

  phase_t                phase_r;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic                  on_r, on_nxt;
  owner_t                owner_r;
  logic [TIME_WIDTH-1:0] last_ovr_r, last_ovr_nxt;

  logic [TIME_WIDTH-1:0] phase_age;
  logic [TIME_WIDTH-1:0] ovr_age;
  logic                  hold_done;
  dur_t                  dur;
  owner_t                want;

  assign phase_age = now - start_r;
  assign ovr_age   = now - last_ovr_r;
  assign hold_done = ovr_age >= TIME_WIDTH'(cfg.hold_time);
  assign dur       = phase_r[0] ? cfg.yellow_time : cfg.green_time;
  assign want      = a_steady ? OWN_A : OWN_B;

  always_comb begin
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    on_nxt       = on_r;
    owner_nxt    = owner_r;
    last_ovr_nxt = last_ovr_r;
    if (a_steady || b_steady) begin
      if ((!on_r || owner_r != want) && hold_done) begin
        on_nxt       = 1'b1;
        owner_nxt    = want;
        phase_nxt    = (want == OWN_A) ? PH_A_GREEN : PH_B_GREEN;
        start_nxt    = now;
        last_ovr_nxt = now;
      end
    end else if (on_r) begin
      on_nxt    = 1'b0;
      owner_nxt = OWN_NONE;
      case (owner_r)
        OWN_A: begin
          phase_nxt = PH_A_YELLOW;
          start_nxt = now;
        end
        OWN_B: begin
          phase_nxt = PH_B_YELLOW;
          start_nxt = now;
        end
        default: begin
        end
      endcase
    end else if (phase_age >= TIME_WIDTH'(dur)) begin
      phase_nxt = phase_r + 2'd1;
      start_nxt = now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_A_GREEN;
      start_r    <= '0;
      on_r       <= 1'b0;
      owner_r    <= OWN_NONE;
      last_ovr_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      start_r    <= start_nxt;
      on_r       <= on_nxt;
      owner_r    <= owner_nxt;
      last_ovr_r <= last_ovr_nxt;
    end
  end

endmodule

FILE: hw/rtl/traffic_light_sensor_override_unit.sv
// Two-way traffic light controller with debounced sensors and green override.
// Each item is one millisecond tick carrying the raw levels of sensors A and B, and gives
// exactly one result item with the six lamps, the phase, the override side and the
// debounced detections after that tick. The block accepts one item every clock cycle while
// input is not held off; the result and the debounce, phase and override state are all
// registered on acceptance. Input is held off only while a finished result waits for the
// downstream side to take it. Configuration registers are to be written through the plain
// write port only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module traffic_light_sensor_override_unit
  import tlso_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tlso_in_if.sink                 in_ch,
  tlso_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  dur_t green_time_r;
  dur_t yellow_time_r;
  dur_t debounce_time_r;
  dur_t hold_time_r;
  logic a_active_r;
  logic b_active_r;

  logic [TIME_WIDTH-1:0] tick_r;
  logic                  step;
  logic                  a_stable_nxt;
  logic                  b_stable_nxt;
  phase_t                phase_nxt;
  owner_t                owner_nxt;
  phase_cfg_t            phase_cfg;
  result_t               res_nxt;
  result_t               res_r;
  logic                  out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_time_r    <= GREEN_TIME_RST;
      yellow_time_r   <= YELLOW_TIME_RST;
      debounce_time_r <= DEBOUNCE_TIME_RST;
      hold_time_r     <= HOLD_TIME_RST;
      a_active_r      <= 1'b0;
      b_active_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GREEN_TIME:    green_time_r    <= cfg_wdata;
        CFG_YELLOW_TIME:   yellow_time_r   <= cfg_wdata;
        CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_wdata;
        CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata;
        CFG_A_ACTIVE:      a_active_r      <= cfg_wdata[0];
        CFG_B_ACTIVE:      b_active_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (step) begin
      tick_r <= tick_r + TIME_WIDTH'(1);
    end
  end

  tlso_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_a (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .raw           (in_ch.a_sensor_raw),
    .active_level  (a_active_r),
    .now           (tick_r),
    .debounce_time (debounce_time_r),
    .stable_nxt    (a_stable_nxt)
  );

  tlso_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_b (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .raw           (in_ch.b_sensor_raw),
    .active_level  (b_active_r),
    .now           (tick_r),
    .debounce_time (debounce_time_r),
    .stable_nxt    (b_stable_nxt)
  );

  assign phase_cfg.green_time  = green_time_r;
  assign phase_cfg.yellow_time = yellow_time_r;
  assign phase_cfg.hold_time   = hold_time_r;

  tlso_phase_ctrl #(.TIME_WIDTH(TIME_WIDTH)) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .now       (tick_r),
    .cfg       (phase_cfg),
    .a_steady  (a_stable_nxt),
    .b_steady  (b_stable_nxt),
    .phase_nxt (phase_nxt),
    .owner_nxt (owner_nxt)
  );

  always_comb begin
    res_nxt.a_red         = (phase_nxt == PH_B_GREEN) || (phase_nxt == PH_B_YELLOW);
    res_nxt.a_amber       = (phase_nxt == PH_A_YELLOW);
    res_nxt.a_green       = (phase_nxt == PH_A_GREEN);
    res_nxt.b_red         = (phase_nxt == PH_A_GREEN) || (phase_nxt == PH_A_YELLOW);
    res_nxt.b_amber       = (phase_nxt == PH_B_YELLOW);
    res_nxt.b_green       = (phase_nxt == PH_B_GREEN);
    res_nxt.phase         = phase_nxt;
    res_nxt.override_side = owner_nxt;
    res_nxt.a_detected    = a_stable_nxt;
    res_nxt.b_detected    = b_stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.a_red         = res_r.a_red;
  assign out_ch.a_amber       = res_r.a_amber;
  assign out_ch.a_green       = res_r.a_green;
  assign out_ch.b_red         = res_r.b_red;
  assign out_ch.b_amber       = res_r.b_amber;
  assign out_ch.b_green       = res_r.b_green;
  assign out_ch.phase         = res_r.phase;
  assign out_ch.override_side = res_r.override_side;
  assign out_ch.a_detected    = res_r.a_detected;
  assign out_ch.b_detected    = res_r.b_detected;

`ifndef SYNTHESIS
  // Exactly one lamp per side is lit in every delivered result.
  a_lamps_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot({out_ch.a_red, out_ch.a_amber, out_ch.a_green}) &&
                     $onehot({out_ch.b_red, out_ch.b_amber, out_ch.b_green}))
    else $error("lamp outputs are not one-hot per side");

  // An active override always holds its side in green.
  a_override_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.override_side == OWN_NONE) ||
                     (out_ch.override_side == OWN_A && out_ch.phase == PH_A_GREEN) ||
                     (out_ch.override_side == OWN_B && out_ch.phase == PH_B_GREEN))
    else $error("override side and phase disagree");

  // Input is stalled only by a pending result that downstream does not take.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a pending result");

  // An accepted item always leaves a result in the output register.
  a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.valid)
    else $error("accepted item produced no result");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the traffic light sensor override unit against a tick predictor.
`timescale 1ns / 1ps

module tb;
  import tlso_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam cfg_idx_t CFG_UNMAPPED_LO = 3'd6;
  localparam cfg_idx_t CFG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic a_raw;
    logic b_raw;
  } sensor_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_GREEN_TIME;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tlso_in_if  in_ch ();
  tlso_out_if out_ch ();

  traffic_light_sensor_override_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  sensor_item_t tick_q[$];
  result_t      lamp_expect_q[$];

  dur_t green_len, yellow_len, settle_len, hold_len;
  logic a_level, b_level;

  logic [31:0] now_tick;
  logic        a_prev, b_prev, a_seen, b_seen;
  logic [31:0] a_since, b_since;
  phase_t      light_phase;
  logic [31:0] light_since;
  logic        ovr_active;
  owner_t      ovr_side;
  logic [31:0] ovr_since;

  int unsigned mismatch_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned override_ticks = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  function automatic logic [31:0] ticks_since(input logic [31:0] now, input logic [31:0] mark);
    return now - mark;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_prediction();
    green_len   = GREEN_TIME_RST;
    yellow_len  = YELLOW_TIME_RST;
    settle_len  = DEBOUNCE_TIME_RST;
    hold_len    = HOLD_TIME_RST;
    a_level     = 1'b0;
    b_level     = 1'b0;
    now_tick    = '0;
    a_prev      = ~a_level;
    b_prev      = ~b_level;
    a_since     = '0;
    b_since     = '0;
    a_seen      = 1'b0;
    b_seen      = 1'b0;
    light_phase = PH_A_GREEN;
    light_since = '0;
    ovr_active  = 1'b0;
    ovr_side    = OWN_NONE;
    ovr_since   = '0;
  endtask

  task automatic settle_sensor(input logic raw, input logic level, input logic [31:0] now,
                               inout logic prev, inout logic [31:0] since, inout logic seen);
    if (raw != prev) begin
      prev  = raw;
      since = now;
    end else if (ticks_since(now, since) >= 32'(settle_len)) begin
      seen = (raw == level);
    end
  endtask

  task automatic grant_green(input owner_t side, input logic [31:0] now);
    if (!ovr_active || ovr_side != side) begin
      if (ticks_since(now, ovr_since) >= 32'(hold_len)) begin
        ovr_active  = 1'b1;
        ovr_side    = side;
        light_phase = (side == OWN_A) ? PH_A_GREEN : PH_B_GREEN;
        light_since = now;
        ovr_since   = now;
      end
    end
  endtask

  task automatic predict_tick(input sensor_item_t item, output result_t lamps);
    logic [31:0] now;
    dur_t        span;
    now = now_tick;
    settle_sensor(item.a_raw, a_level, now, a_prev, a_since, a_seen);
    settle_sensor(item.b_raw, b_level, now, b_prev, b_since, b_seen);
    if (a_seen) begin
      grant_green(OWN_A, now);
    end else if (b_seen) begin
      grant_green(OWN_B, now);
    end else if (ovr_active) begin
      ovr_active = 1'b0;
      if (ovr_side == OWN_A) begin
        light_phase = PH_A_YELLOW;
        light_since = now;
      end else if (ovr_side == OWN_B) begin
        light_phase = PH_B_YELLOW;
        light_since = now;
      end
      ovr_side = OWN_NONE;
    end else begin
      span = light_phase[0] ? yellow_len : green_len;
      if (ticks_since(now, light_since) >= 32'(span)) begin
        light_phase = light_phase + 2'd1;
        light_since = now;
      end
    end
    lamps.a_red         = (light_phase == PH_B_GREEN) || (light_phase == PH_B_YELLOW);
    lamps.a_amber       = (light_phase == PH_A_YELLOW);
    lamps.a_green       = (light_phase == PH_A_GREEN);
    lamps.b_red         = (light_phase == PH_A_GREEN) || (light_phase == PH_A_YELLOW);
    lamps.b_amber       = (light_phase == PH_B_YELLOW);
    lamps.b_green       = (light_phase == PH_B_GREEN);
    lamps.phase         = light_phase;
    lamps.override_side = ovr_side;
    lamps.a_detected    = a_seen;
    lamps.b_detected    = b_seen;
    now_tick = now_tick + 32'd1;
  endtask

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GREEN_TIME:    green_len = data;
      CFG_YELLOW_TIME:   yellow_len = data;
      CFG_DEBOUNCE_TIME: settle_len = data;
      CFG_HOLD_TIME:     hold_len = data;
      CFG_A_ACTIVE:      a_level = data[0];
      CFG_B_ACTIVE:      b_level = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input dur_t g, input dur_t y, input dur_t d, input dur_t h,
                               input logic aa, input logic ba, input bit with_unmapped);
    logic [CFG_DATA_W-1:0] noisy;
    write_reg(CFG_GREEN_TIME, g);
    write_reg(CFG_YELLOW_TIME, y);
    write_reg(CFG_DEBOUNCE_TIME, d);
    write_reg(CFG_HOLD_TIME, h);
    noisy = CFG_DATA_W'($urandom);
    noisy[0] = aa;
    write_reg(CFG_A_ACTIVE, noisy);
    noisy = CFG_DATA_W'($urandom);
    noisy[0] = ba;
    write_reg(CFG_B_ACTIVE, noisy);
    if (with_unmapped) begin
      write_reg(CFG_UNMAPPED_LO, CFG_DATA_W'($urandom));
      write_reg(CFG_UNMAPPED_HI, CFG_DATA_W'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || lamp_expect_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_run(input logic a, input logic b, input int unsigned n);
    sensor_item_t item;
    item.a_raw = a;
    item.b_raw = b;
    repeat (n) tick_q.push_back(item);
  endtask

  // Runs of held sensor levels of random length up to run_max, mixed with single-tick noise.
  task automatic queue_traffic(input int unsigned n, input int unsigned run_max);
    int unsigned left;
    int unsigned len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(1, run_max);
      else len = 1;
      if (len > left) len = left;
      queue_run(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len);
      left -= len;
    end
  endtask

  always @(posedge clk) begin : tick_driver
    result_t      lamps;
    sensor_item_t taken;
    sensor_item_t queued;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.a_sensor_raw <= 1'b0;
      in_ch.b_sensor_raw <= 1'b0;
      in_gap             <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.a_raw = in_ch.a_sensor_raw;
        taken.b_raw = in_ch.b_sensor_raw;
        predict_tick(taken, lamps);
        lamp_expect_q.push_back(lamps);
        ticks_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (tick_q.size() != 0) begin
          queued = tick_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.a_sensor_raw <= queued.a_raw;
          in_ch.b_sensor_raw <= queued.b_raw;
          in_gap             <= pick_gap(in_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : lamp_monitor
    result_t     want;
    int unsigned stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lamp_expect_q.size() == 0) begin
          $error("result item arrived with no expectation pending");
          mismatch_count++;
        end else begin
          want = lamp_expect_q.pop_front();
          check_field("a_red", 2'(want.a_red), 2'(out_ch.a_red));
          check_field("a_amber", 2'(want.a_amber), 2'(out_ch.a_amber));
          check_field("a_green", 2'(want.a_green), 2'(out_ch.a_green));
          check_field("b_red", 2'(want.b_red), 2'(out_ch.b_red));
          check_field("b_amber", 2'(want.b_amber), 2'(out_ch.b_amber));
          check_field("b_green", 2'(want.b_green), 2'(out_ch.b_green));
          check_field("phase", want.phase, out_ch.phase);
          check_field("override_side", want.override_side, out_ch.override_side);
          check_field("a_detected", 2'(want.a_detected), 2'(out_ch.a_detected));
          check_field("b_detected", 2'(want.b_detected), 2'(out_ch.b_detected));
          if (want.override_side != OWN_NONE) override_ticks++;
        end
      end
      if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else if (out_ch.valid && out_ch.ready) begin
        stall = pick_gap(out_calm);
        out_ch.ready <= (stall == 0);
        out_stall    <= (stall == 0) ? 0 : stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned run_max;
    dur_t        g, y, d, h;
    reset_prediction();
    in_ch.valid        = 1'b0;
    in_ch.a_sensor_raw = 1'b0;
    in_ch.b_sensor_raw = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // A few ticks under the reset register values.
    queue_run(1'b1, 1'b1, 1);
    queue_run(1'b0, 1'b0, 1);
    queue_run(1'b1, 1'b0, 1);
    queue_run(1'b0, 1'b1, 1);
    wait_idle();

    // Short timing: normal cycle, A override, both detect, B takeover, clear, noise.
    apply_setting(16'd2, 16'd1, 16'd1, 16'd4, 1'b1, 1'b1, 1'b0);
    queue_run(1'b0, 1'b0, 3);
    queue_run(1'b1, 1'b0, 3);
    queue_run(1'b1, 1'b1, 2);
    queue_run(1'b0, 1'b1, 3);
    queue_run(1'b0, 1'b0, 3);
    queue_run(1'b1, 1'b0, 1);
    queue_run(1'b0, 1'b1, 1);
    queue_run(1'b0, 1'b0, 2);
    wait_idle();

    // Zero phase durations advance the cycle on every quiet tick.
    apply_setting(16'd0, 16'd0, 16'd1, 16'd4, 1'b1, 1'b1, 1'b0);
    queue_run(1'b0, 1'b0, 4);

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      case (p)
        0: begin
          apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
          run_max = 20;
        end
        1: begin
          apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
          run_max = 6;
        end
        2: begin
          // Hold time so long that detections only freeze the phase.
          apply_setting(16'd2, 16'd1, 16'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
          run_max = 8;
        end
        3: begin
          apply_setting(16'd1, 16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b0);
          run_max = 8;
        end
        4: begin
          apply_setting(GREEN_TIME_RST, YELLOW_TIME_RST, DEBOUNCE_TIME_RST, HOLD_TIME_RST,
                        1'b0, 1'b0, 1'b0);
          run_max = 100;
        end
        default: begin
          g = dur_t'($urandom_range(0, 12));
          y = dur_t'($urandom_range(0, 6));
          d = dur_t'($urandom_range(0, 8));
          h = dur_t'($urandom_range(0, 30));
          apply_setting(g, y, d, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'b0);
          run_max = d + h / 2 + 6;
        end
      endcase
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      queue_traffic((p == 4) ? 120 : 65, run_max);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (lamp_expect_q.size() != 0) begin
      $error("%0d expected result items never arrived", lamp_expect_q.size());
      mismatch_count++;
    end
    $display("Checked %0d sensor ticks across %0d register settings.", ticks_sent, settings_used);
    $display("%0d results showed an active override; %0d mismatches.", override_ticks,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
